// ===== rtl/tgbc_pkg.sv =====
// Shared constants for the tile grid box collision unit.
`timescale 1ns / 1ps
`default_nettype none

package tgbc_pkg;

  // Tile store geometry
  localparam int MAX_TILES   = 1024;
  localparam int TILE_ADDR_W = $clog2(MAX_TILES);
  localparam int KIND_W      = 8;

  // Kind value that marks a passable tile
  localparam logic [KIND_W-1:0] KIND_PASSABLE = 8'd1;

  // Register field widths
  localparam int MAP_DIM_W  = 6;
  localparam int TILE_DIM_W = 7;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;

  // Request modes
  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH   = 2'd0,
    REG_MAP_HEIGHT  = 2'd1,
    REG_TILE_WIDTH  = 2'd2,
    REG_TILE_HEIGHT = 2'd3
  } cfg_reg_t;

  // Box edges arrive as 18-bit signed values with four fraction bits
  localparam int BOX_W = 18;

  // Tile edges reach 63 * 127 * 32, which fits in 19 signed bits; 20 are used
  localparam int COORD_W = 20;

  // Linear slot x + y * width reaches 62 + 62 * 63
  localparam int SLOT_W = 12;

endpackage

`default_nettype wire

// ===== rtl/tgbc_ram.sv =====
// Single-port synchronous RAM holding the tile kinds.
`timescale 1ns / 1ps
`default_nettype none

module tgbc_ram #(
  parameter int DEPTH  = tgbc_pkg::MAX_TILES,
  parameter int WIDTH  = tgbc_pkg::KIND_W,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tile_grid_box_collision_unit.sv =====
// Top level of the tile grid box collision unit: tile store, scan sequencer and result.
`timescale 1ns / 1ps
`default_nettype none

// The unit keeps a map of tile kinds and tests boxes against it.
// A request is accepted at a rising edge where start is high and busy is low.
// With in_mode low the request writes in_tile_kind to slot in_tile_address;
// it gives no result and leaves busy low.
// With in_mode high the request is a box query. The tiles are scanned in
// row-major order, one tile store read per cycle, and passable tiles
// (kind 1) are skipped. The scan stops at the first overlapping tile.
// A query over a map of W by H tiles reads at most W * H tiles, one at a time
// through the single read port of the tile store, before the result strobe.
// An empty map answers with a miss without a scan.
// The result is shown on out_hit and out_hit_kind for exactly one cycle with
// out_valid high; the receiver cannot stall it. A new request may be
// accepted in that same cycle.
// Configuration writes through cfg_we, cfg_index and cfg_wdata are to be made
// while the unit is idle; the unit does not enforce this. Reset restores a 16
// by 16 map of 16 by 16 pixel tiles; the tile store contents are undefined until written.

module tile_grid_box_collision_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_mode,
  input  wire logic [9:0]                          in_tile_address,
  input  wire logic [tgbc_pkg::KIND_W-1:0]         in_tile_kind,
  input  wire logic signed [tgbc_pkg::BOX_W-1:0]   in_box_left,
  input  wire logic signed [tgbc_pkg::BOX_W-1:0]   in_box_top,
  input  wire logic signed [tgbc_pkg::BOX_W-1:0]   in_box_right,
  input  wire logic signed [tgbc_pkg::BOX_W-1:0]   in_box_bottom,
  output logic                                     out_valid,
  output logic                                     out_hit,
  output logic      [tgbc_pkg::KIND_W-1:0]         out_hit_kind,
  input  wire logic                                cfg_we,
  input  wire logic [tgbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tgbc_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int CW = tgbc_pkg::COORD_W;
  localparam int MW = tgbc_pkg::MAP_DIM_W;
  localparam int TW = tgbc_pkg::TILE_DIM_W;
  localparam int SW = tgbc_pkg::SLOT_W;
  localparam int KW = tgbc_pkg::KIND_W;
  localparam int AW = tgbc_pkg::TILE_ADDR_W;

  localparam logic [MW-1:0] MAP_DIM_RESET  = 6'd16;
  localparam logic [TW-1:0] TILE_DIM_RESET = 7'd16;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  // Configuration registers
  logic [MW-1:0] map_width_r, map_height_r;
  logic [TW-1:0] tile_width_r, tile_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r   <= MAP_DIM_RESET;
      map_height_r  <= MAP_DIM_RESET;
      tile_width_r  <= TILE_DIM_RESET;
      tile_height_r <= TILE_DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgbc_pkg::REG_MAP_WIDTH:   map_width_r   <= cfg_wdata[MW-1:0];
        tgbc_pkg::REG_MAP_HEIGHT:  map_height_r  <= cfg_wdata[MW-1:0];
        tgbc_pkg::REG_TILE_WIDTH:  tile_width_r  <= cfg_wdata[TW-1:0];
        tgbc_pkg::REG_TILE_HEIGHT: tile_height_r <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // Doubled tile size in sixteenths of a pixel
  logic signed [CW-1:0] step_x, step_y;
  assign step_x = $signed(CW'({tile_width_r, 5'b0}));
  assign step_y = $signed(CW'({tile_height_r, 5'b0}));

  // Sequencer and scan registers
  state_t               state_r, state_nxt;
  logic [MW-1:0]        x_r, x_nxt, y_r, y_nxt;
  logic [SW-1:0]        slot_r, slot_nxt;
  logic signed [CW-1:0] x1_r, x1_nxt, y1_r, y1_nxt;
  logic                 last_r, last_nxt;
  logic signed [CW-1:0] left_r, top_r, right_r, bottom_r;

  // Read stage: one tile read in flight with its geometry verdict
  logic p_valid_r, p_valid_nxt;
  logic p_geo_r, p_geo_nxt;
  logic p_inr_r, p_inr_nxt;

  // Result registers
  logic          out_valid_r, out_valid_nxt;
  logic          out_hit_r, out_hit_nxt;
  logic [KW-1:0] out_hit_kind_r, out_hit_kind_nxt;

  logic          accept, issue, hit_now, geo_now, in_range, row_end;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [KW-1:0] rd_kind;
  logic signed [CW-1:0] x2, y2;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // Overlap test for the tile being issued; touching edges count as overlap
  assign x2       = x1_r + step_x;
  assign y2       = y1_r + step_y;
  assign geo_now  = !((left_r > x2) || (x1_r > right_r) || (top_r > y2) || (y1_r > bottom_r));
  assign in_range = (32'(slot_r) < 32'(tgbc_pkg::MAX_TILES));
  assign row_end  = (x_r == map_width_r - MW'(1));

  assign issue   = (state_r == S_SCAN) && !last_r;
  assign hit_now = p_valid_r && p_inr_r && p_geo_r && (rd_kind != tgbc_pkg::KIND_PASSABLE);

  // Tile store port: writes while idle, scan reads otherwise
  assign ram_we   = accept && (in_mode == tgbc_pkg::MODE_WRITE) &&
                    (32'(in_tile_address) < 32'(tgbc_pkg::MAX_TILES));
  assign ram_addr = (state_r == S_IDLE) ? AW'(in_tile_address) : AW'(slot_r);

  tgbc_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (issue),
    .addr  (ram_addr),
    .wdata (in_tile_kind),
    .rdata (rd_kind)
  );

  // Next-state logic for the scan
  always_comb begin
    state_nxt        = state_r;
    x_nxt            = x_r;
    y_nxt            = y_r;
    slot_nxt         = slot_r;
    x1_nxt           = x1_r;
    y1_nxt           = y1_r;
    last_nxt         = last_r;
    p_valid_nxt      = 1'b0;
    p_geo_nxt        = p_geo_r;
    p_inr_nxt        = p_inr_r;
    out_valid_nxt    = 1'b0;
    out_hit_nxt      = out_hit_r;
    out_hit_kind_nxt = out_hit_kind_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_mode == tgbc_pkg::MODE_QUERY)) begin
          x_nxt    = '0;
          y_nxt    = '0;
          slot_nxt = '0;
          x1_nxt   = '0;
          y1_nxt   = '0;
          last_nxt = 1'b0;
          if ((map_width_r == '0) || (map_height_r == '0)) begin
            // Nothing to scan: answer with a miss at once
            out_valid_nxt    = 1'b1;
            out_hit_nxt      = 1'b0;
            out_hit_kind_nxt = '0;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Issue the next tile in row-major order
        if (issue) begin
          p_valid_nxt = 1'b1;
          p_geo_nxt   = geo_now;
          p_inr_nxt   = in_range;
          slot_nxt    = slot_r + SW'(1);
          if (row_end) begin
            x_nxt  = '0;
            x1_nxt = '0;
            y_nxt  = y_r + MW'(1);
            y1_nxt = y1_r + step_y;
            if (y_r == map_height_r - MW'(1)) begin
              last_nxt = 1'b1;
            end
          end else begin
            x_nxt  = x_r + MW'(1);
            x1_nxt = x1_r + step_x;
          end
        end
        // Judge the tile whose kind has just been read
        if (hit_now) begin
          out_valid_nxt    = 1'b1;
          out_hit_nxt      = 1'b1;
          out_hit_kind_nxt = rd_kind;
          p_valid_nxt      = 1'b0;
          state_nxt        = S_IDLE;
        end else if (last_r) begin
          out_valid_nxt    = 1'b1;
          out_hit_nxt      = 1'b0;
          out_hit_kind_nxt = '0;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r            <= x_nxt;
    y_r            <= y_nxt;
    slot_r         <= slot_nxt;
    x1_r           <= x1_nxt;
    y1_r           <= y1_nxt;
    p_geo_r        <= p_geo_nxt;
    p_inr_r        <= p_inr_nxt;
    out_hit_r      <= out_hit_nxt;
    out_hit_kind_r <= out_hit_kind_nxt;
    if (accept && (in_mode == tgbc_pkg::MODE_QUERY)) begin
      left_r   <= CW'(in_box_left);
      top_r    <= CW'(in_box_top);
      right_r  <= CW'(in_box_right);
      bottom_r <= CW'(in_box_bottom);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_hit_kind = out_hit_kind_r;

  // A result is only shown once the scan has finished
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while a scan is running");

  // A miss always reports kind zero
  a_miss_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_hit_kind_r == '0))
    else $error("miss reported with a non-zero kind");

  // A hit never names a passable tile
  a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (out_hit_kind_r != tgbc_pkg::KIND_PASSABLE))
    else $error("hit reported on a passable tile");

  // A query over a non-empty map keeps the unit busy in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == tgbc_pkg::MODE_QUERY) && (map_width_r != '0) &&
     (map_height_r != '0)) |=> busy)
    else $error("query request did not start a scan");

  // A read is in flight only during a scan
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> (state_r == S_SCAN))
    else $error("tile read outstanding outside a scan");

endmodule

`default_nettype wire
